>>> design/ordered_timer_queue_assert.svh
`ifndef ORDERED_TIMER_QUEUE_ASSERT_SVH
`define ORDERED_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OTQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ordered_timer_queue: assertion failed");

// Next-cycle implication, checked outside reset.
`define OTQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ordered_timer_queue: assertion failed");

`endif

>>> design/otq_pkg.sv
package otq_pkg;
    localparam int DEPTH   = 16;
    localparam int SW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OUT_MAX = 16;
    localparam int NW      = $clog2(OUT_MAX + 1);
    localparam int EW      = $clog2(OUT_MAX);

    localparam logic [62:0] TIME_MAX      = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [19:0] MIN_DELAY_RST = 20'd100;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_ADD       = 2'd0,
        K_CANCEL    = 2'd1,
        K_EXPIRED   = 2'd2,
        K_IDLE_TICK = 2'd3
    } t_kind;

    typedef struct packed {
        logic        add_try;
        logic        clr;
        logic        rearm;
        logic [62:0] now;
        logic [62:0] dl;
        logic [31:0] per;
        logic [31:0] tag;
    } t_cell_cmd;

    typedef struct packed {
        logic        valid;
        logic [62:0] deadline;
        logic [31:0] tag;
    } t_cell_stat;

    function automatic logic [3:0] to_slot4(input logic [SW-1:0] s);
        logic [SW+3:0] t;
        t = {4'b0, s};
        return t[3:0];
    endfunction
endpackage

>>> design/otq_cell.sv
module otq_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  otq_pkg::t_cell_cmd     i_cmd,
    input  logic                   i_sel,
    input  logic                   i_picked,
    input  logic                   i_free_seen,
    input  logic                   i_all_lt,
    output logic                   o_free_seen,
    output logic                   o_all_lt,
    output otq_pkg::t_cell_stat    o_stat
);
    import otq_pkg::*;

    logic        r_valid;
    logic [62:0] r_deadline;
    logic [31:0] r_period;
    logic [31:0] r_tag;
    logic        w_claim;
    logic        w_rearm;
    logic [63:0] w_sum;

    assign w_claim     = i_cmd.add_try & !r_valid & !i_free_seen;
    assign w_rearm     = i_cmd.rearm & i_picked;
    assign o_free_seen = i_free_seen | !r_valid;
    assign o_all_lt    = i_all_lt & (!r_valid | (i_cmd.dl < r_deadline));
    assign w_sum       = {1'b0, i_cmd.now} + {32'b0, r_period};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_claim) begin
            r_valid <= 1'b1;
        end else if (i_cmd.clr & i_sel) begin
            r_valid <= 1'b0;
        end else if (w_rearm & (r_period == 32'd0)) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_claim) begin
            r_deadline <= i_cmd.dl;
            r_period   <= i_cmd.per;
            r_tag      <= i_cmd.tag;
        end else if (w_rearm & (r_period != 32'd0)) begin
            r_deadline <= w_sum[63] ? TIME_MAX : w_sum[62:0];
        end
    end

    assign o_stat = '{valid: r_valid, deadline: r_deadline, tag: r_tag};
endmodule

>>> design/ordered_timer_queue.sv
// Add and cancel update the timer cells, then scan them for the next
// deadline before the result word. A tick picks each expired timer by a
// scan of the timer cells, rearms or frees them, scans for the next deadline
// and emits one word per cycle while not stalled. One item is in work at a time.
// Reset is synchronous and active low; it frees all timers, zeroes the tag
// counter and sets min_delay to 100.
module ordered_timer_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // now[62:0], deadline[125:63], period[157:126], handle_slot[161:158],
    // handle_tag[193:162], zero fill
    input  logic [199:0] i_s_tdata,
    // op[1:0]
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // slot[3:0], tag[35:4], earliest_changed[36], ok[37], next_valid[38],
    // next_delay[101:39], zero fill
    output logic [103:0] o_m_tdata,
    // kind[1:0]
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import otq_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_ADD   = 10'b00_0000_0010,
        S_CANC  = 10'b00_0000_0100,
        S_PICK  = 10'b00_0000_1000,
        S_PSEL  = 10'b00_0001_0000,
        S_REARM = 10'b00_0010_0000,
        S_NXT   = 10'b00_0100_0000,
        S_DLY   = 10'b00_1000_0000,
        S_FLR   = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } t_state;

    t_state      r_state;
    t_op         r_op;
    logic [62:0] r_now;
    logic [62:0] r_dl;
    logic [31:0] r_per;
    logic [3:0]  r_hs;
    logic [31:0] r_ht;
    logic [31:0] r_tagc;
    logic [19:0] r_min;
    logic [SW-1:0] r_idx;
    logic        r_found;
    logic [62:0] r_best;
    logic [SW-1:0] r_bidx;
    logic [DEPTH-1:0] r_picked;
    logic [SW-1:0] r_list [OUT_MAX];
    logic [NW-1:0] r_npick;
    logic [EW-1:0] r_emit;
    logic        r_ok;
    logic        r_ec;
    logic [3:0]  r_rslot;
    logic [31:0] r_rtag;
    logic [62:0] r_diff;
    logic [62:0] r_delay;
    logic        r_nv;
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [101:0] r_out_data;
    logic        r_out_last;

    t_cell_cmd   w_cmd;
    t_cell_stat  w_stat [DEPTH];
    logic [DEPTH:0] w_free;
    logic [DEPTH:0] w_lt;
    logic [DEPTH-1:0] w_sel;
    logic [SW-1:0] w_cidx;
    logic [SW-1:0] w_free_idx;
    logic        w_hit;
    logic        w_accept;
    t_cell_stat  w_cur;
    logic        w_cand;
    logic        w_better;
    logic        w_idx_last;
    logic        w_load;
    logic [SW-1:0] w_eslot;
    logic        w_elast;

    assign w_accept   = i_s_tvalid & o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign pready     = 1'b1;
    assign prdata     = (paddr == 3'd0) ? {12'b0, r_min} : 32'd0;

    assign w_cidx = SW'(r_hs);
    assign w_hit  = ({3'b0, r_hs} < 7'(DEPTH)) & w_stat[w_cidx].valid
                  & (w_stat[w_cidx].tag == r_ht);

    always_comb begin
        w_cmd.add_try = (r_state == S_ADD);
        w_cmd.clr     = (r_state == S_CANC) & w_hit;
        w_cmd.rearm   = (r_state == S_REARM);
        w_cmd.now     = r_now;
        w_cmd.dl      = r_dl;
        w_cmd.per     = r_per;
        w_cmd.tag     = r_tagc + 32'd1;
    end

    assign w_free[0] = 1'b0;
    assign w_lt[0]   = 1'b1;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_sel[g] = (w_cidx == SW'(g));
        otq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_sel       (w_sel[g]),
            .i_picked    (r_picked[g]),
            .i_free_seen (w_free[g]),
            .i_all_lt    (w_lt[g]),
            .o_free_seen (w_free[g+1]),
            .o_all_lt    (w_lt[g+1]),
            .o_stat      (w_stat[g])
        );
    end

    always_comb begin
        w_free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!w_stat[i].valid) begin
                w_free_idx = SW'(i);
            end
        end
    end

    assign w_cur      = w_stat[r_idx];
    assign w_cand     = (r_state == S_PICK)
                      ? (w_cur.valid & !r_picked[r_idx] & (w_cur.deadline <= r_now))
                      : w_cur.valid;
    assign w_better   = w_cand & (!r_found | (w_cur.deadline < r_best));
    assign w_idx_last = (r_idx == SW'(DEPTH - 1));
    assign w_load     = !r_out_valid | i_m_tready;
    assign w_eslot    = r_list[r_emit];
    assign w_elast    = ((NW'(r_emit) + NW'(1)) == r_npick);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_DELAY_RST;
        end else if (psel & penable & pwrite & pready & (paddr == 3'd0)) begin
            r_min <= pwdata[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) & w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tagc      <= 32'd0;
            r_found     <= 1'b0;
            r_npick     <= '0;
            r_emit      <= '0;
            r_picked    <= '0;
            r_idx       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= t_op'(i_s_tuser);
                        r_now    <= i_s_tdata[62:0];
                        r_dl     <= i_s_tdata[125:63];
                        r_per    <= i_s_tdata[157:126];
                        r_hs     <= i_s_tdata[161:158];
                        r_ht     <= i_s_tdata[193:162];
                        r_picked <= '0;
                        r_npick  <= '0;
                        r_emit   <= '0;
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        priority case (t_op'(i_s_tuser))
                            OP_ADD:    r_state <= S_ADD;
                            OP_CANCEL: r_state <= S_CANC;
                            OP_TICK:   r_state <= S_PICK;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ADD: begin
                    r_ok    <= w_free[DEPTH];
                    r_ec    <= w_free[DEPTH] & w_lt[DEPTH];
                    r_rslot <= w_free[DEPTH] ? to_slot4(w_free_idx) : 4'd0;
                    r_rtag  <= w_free[DEPTH] ? (r_tagc + 32'd1) : 32'd0;
                    if (w_free[DEPTH]) begin
                        r_tagc <= r_tagc + 32'd1;
                    end
                    r_state <= S_NXT;
                end
                S_CANC: begin
                    r_ok    <= w_hit;
                    r_ec    <= 1'b0;
                    r_rslot <= r_hs;
                    r_rtag  <= r_ht;
                    r_state <= S_NXT;
                end
                S_PICK, S_NXT: begin
                    if (w_better) begin
                        r_found <= 1'b1;
                        r_best  <= w_cur.deadline;
                        r_bidx  <= r_idx;
                    end
                    r_idx <= w_idx_last ? '0 : r_idx + SW'(1);
                    if (w_idx_last) begin
                        r_state <= (r_state == S_PICK) ? S_PSEL : S_DLY;
                    end
                end
                S_PSEL: begin
                    r_found <= 1'b0;
                    if (r_found && (r_npick < NW'(OUT_MAX))) begin
                        r_picked[r_bidx]          <= 1'b1;
                        r_list[r_npick[EW-1:0]]   <= r_bidx;
                        r_npick                   <= r_npick + NW'(1);
                        r_state                   <= S_PICK;
                    end else begin
                        r_state <= S_REARM;
                    end
                end
                S_REARM: begin
                    r_found <= 1'b0;
                    r_idx   <= '0;
                    r_state <= S_NXT;
                end
                S_DLY: begin
                    r_diff  <= (r_best > r_now) ? (r_best - r_now) : 63'd0;
                    r_state <= S_FLR;
                end
                S_FLR: begin
                    r_nv    <= r_found;
                    r_delay <= !r_found ? 63'd0
                             : (r_diff < {43'b0, r_min}) ? {43'b0, r_min} : r_diff;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_load) begin
                        if (r_op == OP_TICK && r_npick != '0) begin
                            r_out_kind <= K_EXPIRED;
                            r_out_data <= {r_delay, r_nv, 1'b0, 1'b0,
                                           w_stat[w_eslot].tag, to_slot4(w_eslot)};
                            r_out_last <= w_elast;
                            r_emit     <= r_emit + EW'(1);
                            if (w_elast) begin
                                r_state <= S_IDLE;
                            end
                        end else if (r_op == OP_TICK) begin
                            r_out_kind <= K_IDLE_TICK;
                            r_out_data <= {r_delay, r_nv, 1'b0, 1'b0, 32'd0, 4'd0};
                            r_out_last <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_out_kind <= (r_op == OP_ADD) ? K_ADD : K_CANCEL;
                            r_out_data <= {r_delay, r_nv, r_ok, r_ec, r_rtag, r_rslot};
                            r_out_last <= 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b0, r_out_data};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

`include "ordered_timer_queue_assert.svh"

    `OTQ_ASSERT_NOW(a_pick_bound, 1'b1, r_npick <= NW'(OUT_MAX))
    `OTQ_ASSERT_NEXT(a_none_op_idle, w_accept && (i_s_tuser == OP_NONE), r_state == S_IDLE)
    `OTQ_ASSERT_NOW(a_emit_in_list, (r_state == S_EMIT) && (r_op == OP_TICK) && (r_npick != '0), NW'(r_emit) < r_npick)
endmodule
